// ===== rtl/iee_pkg.sv =====
// Shared types and codes for the infix expression evaluator.
package iee_pkg;

  // Token kinds on the input channel
  typedef enum logic [1:0] {
    MODE_VALUE = 2'd0,
    MODE_OPER  = 2'd1,
    MODE_END   = 2'd2
  } mode_e;

  // Operator codes, also the operator stack entry format
  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_CLOSE = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5
  } op_e;

  // Result status codes
  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_DIV0  = 3'd1;
  localparam logic [2:0] STATUS_PAREN = 3'd2;
  localparam logic [2:0] STATUS_LEFT  = 3'd3;
  localparam logic [2:0] STATUS_STACK = 3'd4;

  // Sticky error flag bit positions
  localparam int FLG_DIV0  = 0;
  localparam int FLG_PAREN = 1;
  localparam int FLG_LEFT  = 2;
  localparam int FLG_STACK = 3;

  // Controller sequencer states
  typedef enum logic [3:0] {
    CS_IDLE,
    CS_OP_RD,
    CS_OP_CHK,
    CS_POP_B,
    CS_POP_A,
    CS_CALC,
    CS_WAIT,
    CS_RES_RD,
    CS_RES
  } ctl_state_t;

  // Arithmetic unit states
  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_FIX,
    AS_DONE
  } alu_state_t;

  // Controller to arithmetic unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  // Arithmetic unit to controller
  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

endpackage

// ===== rtl/infix_expression_evaluator_top.sv =====
// Infix expression evaluator: token sequencer, value and operator stacks, shared ALU.
// Tokens arrive one per transfer; a value token or an open parenthesis is
// pushed as it arrives. Any other operator scans the operator stack, each
// look reading the top entry and then checking it (only the read once the
// stack is empty), and every reduction it triggers pops two values and then
// runs the shared arithmetic unit: add and subtract are done directly, and
// multiply and divide work one bit per cycle, divide with a final sign fix.
// An end token reduces everything left the same way, then pops the result
// and loads the output register; the result waits there while new tokens
// are taken, and a second end token stalls until it has gone. The input is
// not ready while a token is being worked on.
module infix_expression_evaluator_top import iee_pkg::*; #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16,
  parameter int DATA_WIDTH     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_token_value,
  input  logic [2:0]         in_operator_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status
);

  localparam int VA_W = $clog2(VALUE_DEPTH);
  localparam int VC_W = $clog2(VALUE_DEPTH + 1);
  localparam int OA_W = $clog2(OPERATOR_DEPTH);
  localparam int OC_W = $clog2(OPERATOR_DEPTH + 1);
  localparam logic [VC_W-1:0] VFULL = VC_W'(VALUE_DEPTH);
  localparam logic [OC_W-1:0] OFULL = OC_W'(OPERATOR_DEPTH);

  ctl_state_t            state_r, state_nxt;
  logic [VC_W-1:0]       vcnt_r, vcnt_nxt, vcnt_m1;
  logic [OC_W-1:0]       ocnt_r, ocnt_nxt, ocnt_m1;
  logic [3:0]            flags_r, flags_nxt;
  logic                  end_r, end_nxt;
  op_e                   tok_op_r, tok_op_nxt;
  op_e                   alu_op_r, alu_op_nxt;
  logic                  b_ok_r, b_ok_nxt;
  logic                  a_ok_r, a_ok_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_result_r, out_result_nxt;
  logic [2:0]            out_status_r, out_status_nxt;

  // Stack memories
  logic [DATA_WIDTH-1:0] vmem [VALUE_DEPTH];
  op_e                   omem [OPERATOR_DEPTH];
  logic                  v_we, v_re, o_we, o_re;
  logic [VA_W-1:0]       v_waddr, v_raddr;
  logic [OA_W-1:0]       o_waddr, o_raddr;
  logic [DATA_WIDTH-1:0] v_wdata, v_rd_r;
  op_e                   o_wdata, o_rd_r;

  // Token decode and misc
  logic                  scan_start;
  logic                  reduce;
  logic                  out_load;
  logic signed [63:0]    tok64;
  logic [DATA_WIDTH-1:0] tok_ext;
  logic [63:0]           res64;

  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [DATA_WIDTH-1:0] alu_a, alu_b, alu_result;

  assign vcnt_m1 = vcnt_r - 1'b1;
  assign ocnt_m1 = ocnt_r - 1'b1;
  assign tok64   = 64'(in_token_value);
  assign tok_ext = tok64[DATA_WIDTH-1:0];
  assign res64   = 64'(v_rd_r);

  // Tokens that need an operator stack scan
  always_comb begin
    scan_start = 1'b0;
    if (in_mode == MODE_END) begin
      scan_start = 1'b1;
    end else if (in_mode == MODE_OPER) begin
      case (in_operator_code) inside
        OP_CLOSE, OP_ADD, OP_SUB, OP_MUL, OP_DIV: scan_start = 1'b1;
        default:                                  scan_start = 1'b0;
      endcase
    end
  end

  // Whether the operator on top must be reduced before this token goes on
  always_comb begin
    if (end_r) begin
      reduce = 1'b1;
    end else begin
      case (tok_op_r) inside
        OP_ADD, OP_SUB: reduce = (o_rd_r >= OP_ADD);
        OP_MUL, OP_DIV: reduce = (o_rd_r >= OP_MUL);
        OP_CLOSE:       reduce = (o_rd_r != OP_OPEN);
        default:        reduce = 1'b0;
      endcase
    end
  end

  assign out_load = (state_r == CS_RES) && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:   if (in_valid && scan_start) state_nxt = CS_OP_RD;
      CS_OP_RD: begin
        if (ocnt_r != '0)  state_nxt = CS_OP_CHK;
        else if (end_r)    state_nxt = CS_RES_RD;
        else               state_nxt = CS_IDLE;
      end
      CS_OP_CHK: begin
        if (!reduce)                 state_nxt = CS_IDLE;
        else if (o_rd_r == OP_OPEN)  state_nxt = CS_OP_RD;
        else                         state_nxt = CS_POP_B;
      end
      CS_POP_B:  state_nxt = CS_POP_A;
      CS_POP_A:  state_nxt = CS_CALC;
      CS_CALC:   state_nxt = CS_WAIT;
      CS_WAIT:   if (alu_rsp.done) state_nxt = CS_OP_RD;
      CS_RES_RD: state_nxt = CS_RES;
      CS_RES:    if (out_load) state_nxt = CS_IDLE;
      default:   state_nxt = CS_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    logic                  push_v;
    logic [DATA_WIDTH-1:0] push_vdata;
    logic                  push_o;
    op_e                   push_odata;
    logic [3:0]            flags_fin;

    push_v         = 1'b0;
    push_vdata     = '0;
    push_o         = 1'b0;
    push_odata     = tok_op_r;
    flags_fin      = flags_r;
    v_we           = 1'b0;
    v_waddr        = vcnt_r[VA_W-1:0];
    v_wdata        = '0;
    v_re           = 1'b0;
    v_raddr        = vcnt_m1[VA_W-1:0];
    o_we           = 1'b0;
    o_waddr        = ocnt_r[OA_W-1:0];
    o_wdata        = tok_op_r;
    o_re           = 1'b0;
    o_raddr        = ocnt_m1[OA_W-1:0];
    vcnt_nxt       = vcnt_r;
    ocnt_nxt       = ocnt_r;
    flags_nxt      = flags_r;
    end_nxt        = end_r;
    tok_op_nxt     = tok_op_r;
    alu_op_nxt     = alu_op_r;
    b_ok_nxt       = b_ok_r;
    a_ok_nxt       = a_ok_r;
    b_nxt          = b_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    alu_req.start  = 1'b0;
    alu_req.op     = alu_op_r;
    alu_a          = a_ok_r ? v_rd_r : '0;
    alu_b          = b_r;
    in_ready       = (state_r == CS_IDLE);

    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          end_nxt    = (in_mode == MODE_END);
          tok_op_nxt = op_e'(in_operator_code);
          if (in_mode == MODE_VALUE) begin
            push_v     = 1'b1;
            push_vdata = tok_ext;
          end else if (in_mode == MODE_OPER && in_operator_code == OP_OPEN) begin
            push_o     = 1'b1;
            push_odata = OP_OPEN;
          end
        end
      end
      CS_OP_RD: begin
        if (ocnt_r != '0) begin
          o_re = 1'b1;
        end else if (!end_r) begin
          // Empty operator stack finishes the token
          if (tok_op_r == OP_CLOSE) flags_nxt[FLG_PAREN] = 1'b1;
          else                      push_o = 1'b1;
        end
      end
      CS_OP_CHK: begin
        if (reduce) begin
          ocnt_nxt = ocnt_m1;
          if (o_rd_r == OP_OPEN) flags_nxt[FLG_PAREN] = 1'b1;
          else                   alu_op_nxt = o_rd_r;
        end else if (tok_op_r == OP_CLOSE) begin
          ocnt_nxt = ocnt_m1;
        end else begin
          push_o = 1'b1;
        end
      end
      CS_POP_B: begin
        // Right operand; an empty stack reads as zero
        if (vcnt_r != '0) begin
          v_re     = 1'b1;
          vcnt_nxt = vcnt_m1;
          b_ok_nxt = 1'b1;
        end else begin
          flags_nxt[FLG_STACK] = 1'b1;
          b_ok_nxt             = 1'b0;
        end
      end
      CS_POP_A: begin
        b_nxt = b_ok_r ? v_rd_r : '0;
        if (vcnt_r != '0) begin
          v_re     = 1'b1;
          vcnt_nxt = vcnt_m1;
          a_ok_nxt = 1'b1;
        end else begin
          flags_nxt[FLG_STACK] = 1'b1;
          a_ok_nxt             = 1'b0;
        end
      end
      CS_CALC: alu_req.start = 1'b1;
      CS_WAIT: begin
        if (alu_rsp.done) begin
          push_v     = 1'b1;
          push_vdata = alu_result;
          if (alu_rsp.div0) flags_nxt[FLG_DIV0] = 1'b1;
        end
      end
      CS_RES_RD: begin
        if (vcnt_r != '0) begin
          v_re     = 1'b1;
          vcnt_nxt = vcnt_m1;
          a_ok_nxt = 1'b1;
        end else begin
          flags_nxt[FLG_STACK] = 1'b1;
          a_ok_nxt             = 1'b0;
        end
      end
      CS_RES: begin
        if (out_load) begin
          flags_fin = flags_r;
          if (vcnt_r != '0) flags_fin[FLG_LEFT] = 1'b1;
          out_result_nxt = a_ok_r ? res64[31:0] : 32'd0;
          if (flags_fin[FLG_DIV0])       out_status_nxt = STATUS_DIV0;
          else if (flags_fin[FLG_PAREN]) out_status_nxt = STATUS_PAREN;
          else if (flags_fin[FLG_LEFT])  out_status_nxt = STATUS_LEFT;
          else if (flags_fin[FLG_STACK]) out_status_nxt = STATUS_STACK;
          else                           out_status_nxt = STATUS_OK;
          vcnt_nxt  = '0;
          ocnt_nxt  = '0;
          flags_nxt = '0;
        end
      end
      default: ;
    endcase

    // Value push with overflow check
    if (push_v) begin
      if (vcnt_r >= VFULL) begin
        flags_nxt[FLG_STACK] = 1'b1;
      end else begin
        v_we     = 1'b1;
        v_wdata  = push_vdata;
        vcnt_nxt = vcnt_r + 1'b1;
      end
    end

    // Operator push with overflow check
    if (push_o) begin
      if (ocnt_r >= OFULL) begin
        flags_nxt[FLG_STACK] = 1'b1;
      end else begin
        o_we     = 1'b1;
        o_wdata  = push_odata;
        ocnt_nxt = ocnt_r + 1'b1;
      end
    end
  end

  // Output register handshake
  always_comb begin
    if (out_load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  // Value stack memory
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (v_re) v_rd_r <= vmem[v_raddr];
  end

  // Operator stack memory
  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    if (o_re) o_rd_r <= omem[o_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      vcnt_r      <= '0;
      ocnt_r      <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      ocnt_r      <= ocnt_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Token and operand registers
  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    tok_op_r     <= tok_op_nxt;
    alu_op_r     <= alu_op_nxt;
    b_ok_r       <= b_ok_nxt;
    a_ok_r       <= a_ok_nxt;
    b_r          <= b_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  iee_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  // Stack counts never pass their depth
  a_vcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VFULL)
    else $error("value count beyond depth");

  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OFULL)
    else $error("operator count beyond depth");

  // A new result only comes from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == CS_RES)
    else $error("result loaded outside result state");

  // Emitting a result leaves both stacks and the flags empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (vcnt_r == '0) && (ocnt_r == '0) && (flags_r == '0))
    else $error("stacks not cleared after result");
`endif

endmodule

// ===== rtl/iee_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
module iee_alu import iee_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  alu_req_t              req,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output alu_rsp_t              rsp,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  alu_state_t            state_r, state_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] opa_r, opa_nxt;
  logic [DATA_WIDTH-1:0] opb_r, opb_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  div0_r, div0_nxt;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH-1:0] mul_sum;
  logic [DATA_WIDTH:0]   rem_sh, rem_sub;
  logic                  div_ge;
  logic [DATA_WIDTH-1:0] rem_new;
  logic                  last_step;

  // Operand magnitudes for the signed divide
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // One multiply step: add the shifted multiplicand when the multiplier bit is set
  assign mul_sum = acc_r + (opb_r[0] ? opa_r : '0);

  // One restoring divide step: remainder in acc_r, dividend/quotient in opa_r
  assign rem_sh  = {acc_r, opa_r[DATA_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, opb_r};
  assign div_ge  = (rem_sh >= {1'b0, opb_r});
  assign rem_new = div_ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];

  assign last_step = (cnt_r == CNT_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_MUL:  state_nxt = AS_MUL;
            OP_DIV:  state_nxt = (mag_b == '0) ? AS_DONE : AS_DIV;
            default: state_nxt = AS_DONE;
          endcase
        end
      end
      AS_MUL:  if (last_step) state_nxt = AS_DONE;
      AS_DIV:  if (last_step) state_nxt = AS_FIX;
      AS_FIX:  state_nxt = AS_DONE;
      AS_DONE: state_nxt = AS_IDLE;
      default: state_nxt = AS_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    div0_nxt = div0_r;
    unique case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          case (req.op)
            OP_ADD: res_nxt = a_i + b_i;
            OP_SUB: res_nxt = a_i - b_i;
            OP_MUL: begin
              opa_nxt = a_i;
              opb_nxt = b_i;
            end
            OP_DIV: begin
              opa_nxt = mag_a;
              opb_nxt = mag_b;
              neg_nxt = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
              if (mag_b == '0) begin
                res_nxt  = '0;
                div0_nxt = 1'b1;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      AS_MUL: begin
        acc_nxt = mul_sum;
        opa_nxt = {opa_r[DATA_WIDTH-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[DATA_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) res_nxt = mul_sum;
      end
      AS_DIV: begin
        acc_nxt = rem_new;
        opa_nxt = {opa_r[DATA_WIDTH-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      // Apply the quotient sign; the most negative over -1 wraps to itself
      AS_FIX:  res_nxt = neg_r ? (~opa_r + 1'b1) : opa_r;
      AS_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      div0_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div0_r  <= div0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  // Outputs
  always_comb begin
    rsp.done = (state_r == AS_DONE);
    rsp.div0 = div0_r;
    result   = res_r;
  end

`ifndef SYNTHESIS
  // A request is only issued while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == AS_IDLE)
    else $error("alu started while busy");

  // Completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("alu done held");
`endif

endmodule

// ===== tb/tb_infix_expression_evaluator_top.sv =====
// Testbench for the infix expression evaluator: token streams checked against a two-stack model.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator_top;
  import iee_pkg::*;

  localparam int VALUE_DEPTH    = 16;
  localparam int OPERATOR_DEPTH = 16;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int MAX_NESTING    = 4;

  // Codes outside the defined set; the block ignores them
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] OP_SPARE_A  = 3'd6;
  localparam logic [2:0] OP_SPARE_B  = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } expr_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = MODE_VALUE;
  logic signed [31:0] in_token_value = '0;
  logic [2:0]         in_operator_code = OP_OPEN;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic [2:0]         out_status;

  infix_expression_evaluator_top #(
    .VALUE_DEPTH   (VALUE_DEPTH),
    .OPERATOR_DEPTH(OPERATOR_DEPTH),
    .DATA_WIDTH    (32)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_token_value  (in_token_value),
    .in_operator_code(in_operator_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_value(out_result_value),
    .out_status      (out_status)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Evaluator state as predicted
  logic [31:0]  val_stack [VALUE_DEPTH];
  op_e          op_stack [OPERATOR_DEPTH];
  int           val_count = 0;
  int           op_count = 0;
  logic [3:0]   err_flags = '0;
  expr_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_req = 0;
  int recv_hold_left = 0;
  int tokens_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  function automatic void push_val(logic [31:0] v);
    if (val_count >= VALUE_DEPTH) begin
      err_flags[FLG_STACK] = 1'b1;
    end else begin
      val_stack[val_count] = v;
      val_count++;
    end
  endfunction

  function automatic logic [31:0] pop_val();
    if (val_count == 0) begin
      err_flags[FLG_STACK] = 1'b1;
      return '0;
    end
    val_count--;
    return val_stack[val_count];
  endfunction

  function automatic void push_op(op_e op);
    if (op_count >= OPERATOR_DEPTH) begin
      err_flags[FLG_STACK] = 1'b1;
    end else begin
      op_stack[op_count] = op;
      op_count++;
    end
  endfunction

  // Signed divide, truncating toward zero; zero divisor gives 0 and a flag
  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    longint sa;
    longint sb;
    longint q;
    sa = $signed(a);
    sb = $signed(b);
    if (sb == 0) begin
      err_flags[FLG_DIV0] = 1'b1;
      return '0;
    end
    q = (sa < 0 ? -sa : sa) / (sb < 0 ? -sb : sb);
    if ((sa < 0) != (sb < 0)) q = -q;
    return q[31:0];
  endfunction

  // Pop one operator and combine the top two values with it
  function automatic void reduce_top();
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    op_count--;
    op = op_stack[op_count];
    if (op == OP_OPEN) begin
      err_flags[FLG_PAREN] = 1'b1;
      return;
    end
    b = pop_val();
    a = pop_val();
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      default: r = quotient(a, b);
    endcase
    push_val(r);
  endfunction

  // Advance the predicted state by one accepted token
  function automatic void eval_token(logic [1:0] m, logic [31:0] v, logic [2:0] code);
    expr_result_t res;
    case (m)
      MODE_VALUE: push_val(v);
      MODE_OPER: begin
        if (code == OP_OPEN) begin
          push_op(OP_OPEN);
        end else if (code == OP_ADD || code == OP_SUB) begin
          while (op_count > 0 && op_stack[op_count - 1] >= OP_ADD) reduce_top();
          push_op(op_e'(code));
        end else if (code == OP_MUL || code == OP_DIV) begin
          while (op_count > 0 && op_stack[op_count - 1] >= OP_MUL) reduce_top();
          push_op(op_e'(code));
        end else if (code == OP_CLOSE) begin
          while (op_count > 0 && op_stack[op_count - 1] != OP_OPEN) reduce_top();
          if (op_count == 0) err_flags[FLG_PAREN] = 1'b1;
          else op_count--;
        end
      end
      MODE_END: begin
        while (op_count > 0) reduce_top();
        res.value = pop_val();
        if (val_count != 0) err_flags[FLG_LEFT] = 1'b1;
        if (err_flags[FLG_DIV0]) res.status = STATUS_DIV0;
        else if (err_flags[FLG_PAREN]) res.status = STATUS_PAREN;
        else if (err_flags[FLG_LEFT]) res.status = STATUS_LEFT;
        else if (err_flags[FLG_STACK]) res.status = STATUS_STACK;
        else res.status = STATUS_OK;
        pending_results.push_back(res);
        val_count = 0;
        op_count = 0;
        err_flags = '0;
      end
      default: ;
    endcase
  endfunction

  // Offer one token, with random idle cycles first, and wait for the transfer
  task automatic send_token(logic [1:0] m, logic [31:0] v, logic [2:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_token_value   <= v;
    in_operator_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    eval_token(m, v, code);
    if (m != MODE_UNUSED && !(m == MODE_OPER && code > OP_DIV)) tokens_sent++;
  endtask

  task automatic send_val(logic [31:0] v);
    send_token(MODE_VALUE, v, 3'($urandom_range(7)));
  endtask

  task automatic send_op(op_e op);
    send_token(MODE_OPER, $urandom, op);
  endtask

  task automatic send_end();
    send_token(MODE_END, $urandom, 3'($urandom_range(7)));
  endtask

  // Stop offering and wait until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom;
      default: return 32'($urandom_range(100)) - 32'd50;
    endcase
  endfunction

  function automatic op_e random_binary_op();
    case ($urandom_range(3))
      0:       return OP_ADD;
      1:       return OP_SUB;
      2:       return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Well-formed expression with random nesting, operators and operands
  task automatic send_random_expression();
    int operands;
    int depth;
    operands = $urandom_range(1, 10);
    depth = 0;
    for (int i = 0; i < operands; i++) begin
      while (depth < MAX_NESTING && $urandom_range(99) < 20) begin
        send_op(OP_OPEN);
        depth++;
      end
      send_val(random_operand());
      while (depth > 0 && $urandom_range(99) < 25) begin
        send_op(OP_CLOSE);
        depth--;
      end
      if (i != operands - 1) send_op(random_binary_op());
    end
    while (depth > 0) begin
      send_op(OP_CLOSE);
      depth--;
    end
    send_end();
  endtask

  // Any token at all, including unused codes
  task automatic send_noise_token();
    send_token(2'($urandom_range(3)), $urandom, 3'($urandom_range(7)));
  endtask

  // Precedence, associativity and wrap at the operand extremes
  task automatic test_precedence();
    send_val(32'h7fff_ffff);
    send_op(OP_MUL);
    send_val(32'h8000_0000);
    send_op(OP_ADD);
    send_val(32'd7);
    send_op(OP_DIV);
    send_val(-32'sd2);
    send_op(OP_SUB);
    send_val(32'd1);
    send_end();
  endtask

  // Most negative over minus one, then a zero divisor
  task automatic test_divide_cases();
    send_op(OP_OPEN);
    send_val(32'h8000_0000);
    send_op(OP_DIV);
    send_val('1);
    send_op(OP_CLOSE);
    send_op(OP_DIV);
    send_val('0);
    send_end();
  endtask

  // Unclosed open, then an unmatched close with nothing to pop
  task automatic test_paren_errors();
    send_op(OP_OPEN);
    send_val(32'd1);
    send_end();
    send_op(OP_CLOSE);
    send_end();
  endtask

  // Leftover values with ignored codes mixed in
  task automatic test_leftover_and_unused();
    send_val(32'd1);
    send_token(MODE_OPER, $urandom, OP_SPARE_A);
    send_token(MODE_UNUSED, $urandom, OP_SPARE_B);
    send_val(32'd2);
    send_end();
  endtask

  // Both stacks up to and one past their depth
  task automatic test_stack_limits();
    for (int n = VALUE_DEPTH; n <= VALUE_DEPTH + 1; n++) begin
      for (int i = 0; i < n; i++) send_val(random_operand());
      send_end();
    end
    for (int lv = OPERATOR_DEPTH / 2; lv <= OPERATOR_DEPTH / 2 + 1; lv++) begin
      for (int i = 0; i < lv; i++) begin
        send_val(32'($urandom_range(9)));
        send_op(OP_ADD);
        send_op(OP_OPEN);
      end
      send_val(32'($urandom_range(9)));
      for (int i = 0; i < lv; i++) send_op(OP_CLOSE);
      send_end();
    end
    for (int i = 0; i <= OPERATOR_DEPTH; i++) send_op(OP_OPEN);
    send_val(random_operand());
    send_end();
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    recv_hold_req = 300;
    for (int i = 0; i < 6; i++) begin
      send_val(random_operand());
      send_op(random_binary_op());
      send_val(random_operand());
      send_end();
    end
    wait_drain();
  endtask

  // Mostly well-formed expressions, some bursts of noise
  task automatic test_random_phase(int idle_pct, int stall_pct, int n_tokens);
    int target;
    target = tokens_sent + n_tokens;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (tokens_sent < target) begin
      if ($urandom_range(99) < 85) begin
        send_random_expression();
      end else begin
        repeat ($urandom_range(1, 4)) send_noise_token();
      end
    end
    send_end();
  endtask

  // Result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (recv_hold_req > 0) begin
      recv_hold_left = recv_hold_req;
      recv_hold_req = 0;
    end
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    expr_result_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: value %0d status %0d", out_result_value, out_status);
        mismatch_count++;
      end else begin
        head = pending_results.pop_front();
        if (out_result_value !== head.value || out_status !== head.status) begin
          if (mismatch_count < 10)
            $display("mismatch: value %0d status %0d, expected value %0d status %0d",
                     out_result_value, out_status, $signed(head.value), head.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_precedence();
    test_divide_cases();
    test_paren_errors();
    test_leftover_and_unused();
    test_stack_limits();
    test_backpressure();
    test_random_phase(0, 0, 150);
    test_random_phase(83, 0, 150);
    test_random_phase(0, 83, 150);
    test_random_phase(19, 19, 150);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
